// ----- src/utf8_symbol_prenormalizer_top_assert.svh -----
// assertion macros for the utf8 symbol prenormalizer checker
// needs only a clock and an active-low reset at the place of use
`ifndef UTF8_SYMBOL_PRENORMALIZER_TOP_ASSERT_SVH
`define UTF8_SYMBOL_PRENORMALIZER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is held
`define USP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define USP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/usp_pkg.sv -----
// shared types, byte codes and rule functions for the utf8 symbol prenormalizer
// no dependencies
package usp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MAX_OUT = 9;

    // ascii codes used by the rules
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    // utf-8 sequence bytes
    localparam logic [7:0] B_E2 = 8'hE2;
    localparam logic [7:0] B_84 = 8'h84;
    localparam logic [7:0] B_83 = 8'h83;
    localparam logic [7:0] B_89 = 8'h89;
    localparam logic [7:0] B_C2 = 8'hC2;
    localparam logic [7:0] B_A5 = 8'hA5;
    localparam logic [7:0] B_EF = 8'hEF;
    localparam logic [7:0] B_BF = 8'hBF;

    // replacement texts
    localparam logic [7:0] C_NEG_SYM [3] = '{8'hE8, 8'hB4, 8'h9F};
    localparam logic [7:0] C_CEL_SYM [9] = '{8'hE6, 8'h91, 8'h84, 8'hE6, 8'hB0,
                                            8'h8F, 8'hE5, 8'hBA, 8'hA6};
    localparam logic [7:0] C_FAHR_SYM [9] = '{8'hE5, 8'h8D, 8'h8E, 8'hE6, 8'hB0,
                                             8'h8F, 8'hE5, 8'hBA, 8'hA6};

    typedef enum logic [2:0] {
        K_PASS,
        K_DROP,
        K_NEG,
        K_CEL,
        K_FAHR
    } t_kind;

    typedef struct packed {
        logic       decided;
        logic [1:0] used;
        t_kind      kind;
    } t_decision;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    // settle the head byte of a window of avail bytes
    function automatic t_decision decide(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [1:0] avail,
        input logic       fin,
        input logic [7:0] prev,
        input logic       prev_valid
    );
        t_decision d;
        d.decided = 1'b1;
        d.used    = 2'd1;
        d.kind    = K_PASS;
        if (b0 == CH_COMMA && prev_valid && is_digit(prev)) begin
            if (avail < 2'd2) d.decided = fin;
            else if (is_digit(b1)) d.kind = K_DROP;
        end else if (b0 == CH_HYPHEN && !(prev_valid && is_alnum(prev))) begin
            if (avail < 2'd2) d.decided = fin;
            else if (is_digit(b1)) d.kind = K_NEG;
        end else if (b0 == B_E2) begin
            if (avail < 2'd2) begin
                d.decided = fin;
            end else if (b1 == B_84) begin
                if (avail < 2'd3) begin
                    d.decided = fin;
                end else if (b2 == B_83) begin
                    d.kind = K_CEL;
                    d.used = 2'd3;
                end else if (b2 == B_89) begin
                    d.kind = K_FAHR;
                    d.used = 2'd3;
                end
            end
        end else if (b0 == B_C2) begin
            if (avail < 2'd2) begin
                d.decided = fin;
            end else if (b1 == B_A5) begin
                d.kind = K_DROP;
                d.used = 2'd2;
            end
        end else if (b0 == B_EF) begin
            if (avail < 2'd2) begin
                d.decided = fin;
            end else if (b1 == B_BF) begin
                if (avail < 2'd3) begin
                    d.decided = fin;
                end else if (b2 == B_A5) begin
                    d.kind = K_DROP;
                    d.used = 2'd3;
                end
            end
        end
        return d;
    endfunction

    function automatic logic [4:0] sym_len(input t_kind kind);
        logic [4:0] len;
        case (kind)
            K_DROP:  len = 5'd0;
            K_NEG:   len = 5'd3;
            K_CEL:   len = 5'd9;
            K_FAHR:  len = 5'd9;
            default: len = 5'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] sym_byte(
        input t_kind      kind,
        input logic [3:0] idx,
        input logic [7:0] b0
    );
        logic [7:0] b;
        case (kind)
            K_NEG:   b = C_NEG_SYM[idx[1:0]];
            K_CEL:   b = C_CEL_SYM[idx];
            K_FAHR:  b = C_FAHR_SYM[idx];
            default: b = b0;
        endcase
        return b;
    endfunction

endpackage

// ----- src/usp_if.sv -----
// valid/ready channel interfaces for the prenormalizer input and output
// depends on usp_pkg
interface usp_in_if;
    import usp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface usp_out_if;
    import usp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              end_of_text;

    modport source (output valid, output out_byte, output has_byte, output end_of_text,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input end_of_text,
                    output ready);
endinterface

// ----- src/utf8_symbol_prenormalizer_top.sv -----
// the first byte of a request is registered and shows in the cycle after the request is taken
// one request per cycle while each yields at most one byte and the output is not stalled; a
//   request that yields n bytes blocks input until they drain, input taken again with the last
// reset: synchronous active-low i_rst_n clears the lookahead, previous byte and queue
// depends on usp_pkg and usp_if
module utf8_symbol_prenormalizer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    usp_in_if.sink       i_in,
    usp_out_if.source    o_out
);
    import usp_pkg::*;

    // lookahead window state
    logic [BYTE_W-1:0] r_la [2];
    logic [1:0]        r_la_cnt;
    logic [BYTE_W-1:0] r_prev;
    logic              r_prev_valid;

    // result register: bytes of the current request, drained from entry 0
    logic [BYTE_W-1:0] r_buf [MAX_OUT];
    logic [3:0]        r_rem;
    logic              r_fin;
    logic              r_marker;

    // next values from the decision logic
    logic [BYTE_W-1:0] n_buf [MAX_OUT];
    logic [3:0]        n_rem;
    logic              n_marker;
    logic [BYTE_W-1:0] n_la [2];
    logic [1:0]        n_la_cnt;
    logic [BYTE_W-1:0] n_prev;

    logic in_acc;
    logic out_acc;

    // take a new request once the queue is empty or its last byte leaves now
    assign i_in.ready = (r_rem == 4'd0) || (r_rem == 4'd1 && o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    assign o_out.valid       = (r_rem != 4'd0);
    assign o_out.out_byte    = r_buf[0];
    assign o_out.has_byte    = !r_marker;
    assign o_out.end_of_text = r_fin && (r_rem == 4'd1);

    // decision pass: settle up to three window bytes, head first
    always_comb begin
        logic [BYTE_W-1:0] w_cur [3];
        logic [BYTE_W-1:0] w_tmp [3];
        logic [1:0]        avail;
        logic [BYTE_W-1:0] prev;
        logic              pv;
        logic              stop;
        logic [4:0]        k;
        logic [4:0]        len;
        logic [4:0]        slot;
        t_decision         d;

        // assemble window from held bytes and the new byte
        w_cur[0] = i_in.in_byte;
        w_cur[1] = '0;
        w_cur[2] = '0;
        if (r_la_cnt == 2'd1) begin
            w_cur[0] = r_la[0];
            w_cur[1] = i_in.in_byte;
        end else if (r_la_cnt >= 2'd2) begin
            w_cur[0] = r_la[0];
            w_cur[1] = r_la[1];
            w_cur[2] = i_in.in_byte;
        end
        avail = (r_la_cnt >= 2'd2) ? 2'd3 : r_la_cnt + 2'd1;
        prev  = r_prev;
        pv    = r_prev_valid;
        stop  = 1'b0;
        k     = '0;
        len   = '0;
        slot  = '0;
        d     = '0;
        for (int j = 0; j < 3; j++) begin
            w_tmp[j] = '0;
        end
        for (int j = 0; j < MAX_OUT; j++) begin
            n_buf[j] = '0;
        end

        for (int it = 0; it < 3; it++) begin
            if (!stop && avail != 2'd0) begin
                d = decide(w_cur[0], w_cur[1], w_cur[2], avail, i_in.last_byte, prev, pv);
                if (!d.decided) begin
                    stop = 1'b1;
                end else begin
                    len = sym_len(d.kind);
                    for (int e = 0; e < MAX_OUT; e++) begin
                        slot = k + 5'(e);
                        if (5'(e) < len && slot < 5'(MAX_OUT)) begin
                            n_buf[slot[3:0]] = sym_byte(d.kind, 4'(e), w_cur[0]);
                        end
                    end
                    k = (k + len > 5'(MAX_OUT)) ? 5'(MAX_OUT) : k + len;
                    // the last consumed byte becomes the previous byte
                    case (d.used)
                        2'd2:    prev = w_cur[1];
                        2'd3:    prev = w_cur[2];
                        default: prev = w_cur[0];
                    endcase
                    pv = 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        w_tmp[j] = w_cur[j];
                    end
                    for (int j = 0; j < 3; j++) begin
                        w_cur[j] = (j + int'(d.used) < 3) ? w_tmp[j + int'(d.used)] : '0;
                    end
                    avail = (d.used > avail) ? 2'd0 : avail - d.used;
                end
            end
        end

        n_la[0]  = w_cur[0];
        n_la[1]  = w_cur[1];
        n_la_cnt = (avail > 2'd2) ? 2'd2 : avail;
        n_prev   = prev;

        // an end of text with no bytes still leaves one marker result
        n_marker = i_in.last_byte && (k == 5'd0);
        n_rem    = n_marker ? 4'd1 : k[3:0];
        if (n_marker) begin
            n_buf[0] = '0;
        end
    end

    // window state, back to empty after the last byte of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la_cnt     <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (in_acc) begin
            if (i_in.last_byte) begin
                r_la_cnt     <= '0;
                r_prev       <= '0;
                r_prev_valid <= 1'b0;
            end else begin
                r_la_cnt     <= n_la_cnt;
                r_prev       <= n_prev;
                r_prev_valid <= (n_prev != r_prev) || r_prev_valid || (n_la_cnt <= r_la_cnt);
            end
        end
    end

    // held bytes carry no reset, only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_la[0] <= n_la[0];
            r_la[1] <= n_la[1];
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_fin    <= 1'b0;
            r_marker <= 1'b0;
        end else if (in_acc) begin
            r_rem    <= n_rem;
            r_fin    <= i_in.last_byte;
            r_marker <= n_marker;
        end else if (out_acc) begin
            r_rem <= r_rem - 4'd1;
        end
    end

    // result bytes: load on a new request, shift on each byte taken
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int j = 0; j < MAX_OUT; j++) begin
                r_buf[j] <= n_buf[j];
            end
        end else if (out_acc) begin
            for (int j = 0; j < MAX_OUT - 1; j++) begin
                r_buf[j] <= r_buf[j + 1];
            end
        end
    end

endmodule

// ----- src/usp_checker.sv -----
// port-level checks for utf8_symbol_prenormalizer_top, bound to every instance
// depends on utf8_symbol_prenormalizer_top_assert.svh
`include "utf8_symbol_prenormalizer_top_assert.svh"

module usp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_last_byte,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_has_byte,
    input logic       i_end_of_text
);
    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // a stalled result blocks new requests
    `USP_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        i_out_valid && !i_out_ready, !i_in_ready, "request taken while result stalled")

    // the end of a text always yields at least one result
    `USP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
        in_acc && i_last_byte, i_out_valid, "no result after last byte")

    // a result without a byte is only the end marker
    `USP_ASSERT_NOW(a_marker_is_end, i_clk, i_rst_n,
        i_out_valid && !i_has_byte, i_end_of_text, "empty result not at end of text")

    // nothing follows the end of a text until a new request arrives
    `USP_ASSERT_NEXT(a_quiet_after_end, i_clk, i_rst_n,
        out_acc && i_end_of_text && !in_acc, !i_out_valid, "result after end of text")

    // a stalled result holds
    `USP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte),
        "stalled result changed")

endmodule

bind utf8_symbol_prenormalizer_top usp_checker u_usp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_last_byte   (i_in.last_byte),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_has_byte    (o_out.has_byte),
    .i_end_of_text (o_out.end_of_text)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for utf8_symbol_prenormalizer_top: directed rows, then random texts
// depends on usp_pkg, usp_if and the prenormalizer top level
module tb_top;
    import usp_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;

    // one rewritten result as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       eot;
    } text_out_t;

    // how a request is checked: by the predictor, by a result typed into the row, or not at all
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } check_t;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        check_t     chk;
        text_out_t  typed;
    } stim_row_t;

    // where the predictor takes the bytes of one decision from
    typedef enum logic [1:0] {
        SYM_HEAD,
        SYM_NEG,
        SYM_CEL,
        SYM_FAHR
    } sym_src_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_BEAT,
        RX_HOLD
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    usp_in_if  text_in ();
    usp_out_if text_out ();

    utf8_symbol_prenormalizer_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (text_in),
        .o_out   (text_out)
    );

    always #6 clk = ~clk;

    // predictor state: held lookahead and the previous original byte
    logic [7:0] held [2];
    int         held_cnt = 0;
    logic [7:0] prev_byte = 8'h00;
    logic       prev_ok = 1'b0;

    text_out_t  step_bytes [$];    // results of the request just taken
    text_out_t  rewritten_q [$];   // results still owed by the block

    // check mode of the request on the input, set along with its data
    check_t     row_chk;
    text_out_t  row_typed;

    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    int burst_left;
    int gap_left;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_phase = 0;

    function automatic logic ascii_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic ascii_alnum(input logic [7:0] c);
        return ascii_digit(c) || (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    function automatic stim_row_t dir_row(input logic [7:0] b, input logic fin,
                                          input check_t chk, input logic [7:0] tb_byte,
                                          input logic tb_has);
        stim_row_t r;
        r.b     = b;
        r.fin   = fin;
        r.chk   = chk;
        r.typed = '{data: tb_byte, has_data: tb_has, eot: fin};
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("tb_top: mismatch: %s", what);
    endtask

    // rewrite one input byte: window = held bytes plus the new one, decide heads
    // until one needs lookahead that has not arrived yet
    task automatic prenormalize_byte(input logic [7:0] b, input logic fin);
        logic [7:0] win [3];
        int         n;
        int         used;
        int         elen;
        logic       settled;
        logic       walking;
        sym_src_t   src;
        text_out_t  r;

        step_bytes.delete();
        n = 0;
        for (int i = 0; i < held_cnt; i++) begin
            win[n] = held[i];
            n++;
        end
        win[n] = b;
        n++;
        walking = 1'b1;
        while (walking && n > 0) begin
            used    = 1;
            elen    = 1;
            src     = SYM_HEAD;
            settled = 1'b1;
            if (win[0] == CH_COMMA && prev_ok && ascii_digit(prev_byte)) begin
                // comma between digits
                if (n < 2) settled = fin;
                else if (ascii_digit(win[1])) elen = 0;
            end else if (win[0] == CH_HYPHEN && !(prev_ok && ascii_alnum(prev_byte))) begin
                // minus sign before a number
                if (n < 2) settled = fin;
                else if (ascii_digit(win[1])) begin
                    src  = SYM_NEG;
                    elen = 3;
                end
            end else if (win[0] == B_E2) begin
                if (n < 2) begin
                    settled = fin;
                end else if (win[1] == B_84) begin
                    if (n < 3) begin
                        settled = fin;
                    end else if (win[2] == B_83) begin
                        src  = SYM_CEL;
                        elen = 9;
                        used = 3;
                    end else if (win[2] == B_89) begin
                        src  = SYM_FAHR;
                        elen = 9;
                        used = 3;
                    end
                end
            end else if (win[0] == B_C2) begin
                if (n < 2) begin
                    settled = fin;
                end else if (win[1] == B_A5) begin
                    elen = 0;
                    used = 2;
                end
            end else if (win[0] == B_EF) begin
                if (n < 2) begin
                    settled = fin;
                end else if (win[1] == B_BF) begin
                    if (n < 3) begin
                        settled = fin;
                    end else if (win[2] == B_A5) begin
                        elen = 0;
                        used = 3;
                    end
                end
            end

            if (!settled) begin
                walking = 1'b0;
            end else begin
                for (int i = 0; i < elen; i++) begin
                    case (src)
                        SYM_NEG:  r.data = C_NEG_SYM[i];
                        SYM_CEL:  r.data = C_CEL_SYM[i];
                        SYM_FAHR: r.data = C_FAHR_SYM[i];
                        default:  r.data = win[0];
                    endcase
                    r.has_data = 1'b1;
                    r.eot      = 1'b0;
                    step_bytes.insert(step_bytes.size(), r);
                end
                prev_byte = win[used-1];
                prev_ok   = 1'b1;
                for (int i = 0; i + used < n; i++) win[i] = win[i+used];
                n -= used;
            end
        end

        held_cnt = n;
        for (int i = 0; i < n; i++) held[i] = win[i];

        if (fin) begin
            // end of text: marker if nothing came out, flag the last result, start over
            if (step_bytes.size() == 0) step_bytes.insert(0, '{8'h00, 1'b0, 1'b0});
            r     = step_bytes.pop_back();
            r.eot = 1'b1;
            step_bytes.insert(step_bytes.size(), r);
            held_cnt  = 0;
            prev_byte = 8'h00;
            prev_ok   = 1'b0;
        end
    endtask

    // scoreboard: results are checked before the request of the same edge is
    // predicted, so one process keeps the order fixed
    always @(posedge clk) begin : scoreboard
        text_out_t want;
        if (rst_n) begin
            if (text_out.valid && text_out.ready) begin
                results_seen++;
                if (rewritten_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d: byte %02h has %b end %b, none owed",
                                              results_seen, text_out.out_byte,
                                              text_out.has_byte, text_out.end_of_text));
                end else begin
                    want = rewritten_q.pop_front();
                    if (text_out.out_byte !== want.data || text_out.has_byte !== want.has_data ||
                        text_out.end_of_text !== want.eot)
                        report_mismatch($sformatf(
                            "result %0d: got byte %02h has %b end %b, want %02h has %b end %b",
                            results_seen, text_out.out_byte, text_out.has_byte,
                            text_out.end_of_text, want.data, want.has_data, want.eot));
                end
            end
            if (text_in.valid && text_in.ready) begin
                // predictor always runs so its state follows the typed rows too
                prenormalize_byte(text_in.in_byte, text_in.last_byte);
                case (row_chk)
                    CHK_ONE:  rewritten_q.insert(rewritten_q.size(), row_typed);
                    CHK_NONE: ;
                    default:  foreach (step_bytes[i])
                                  rewritten_q.insert(rewritten_q.size(), step_bytes[i]);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: switches between random stall patterns, long holds included
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN: text_out.ready = 1'b1;
            RX_COIN: text_out.ready = 1'($urandom_range(0, 1));
            RX_BEAT: text_out.ready = (rx_phase % 3) != 0;
            default: text_out.ready = (rx_phase % 16) >= 10;
        endcase
    end

    // one request: starts and ends at a falling edge; sender idles in bursts and gaps
    task automatic send_byte(input logic [7:0] b, input logic fin, input check_t chk,
                             input text_out_t typed);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        while (gap_left > 0) begin
            text_in.valid = 1'b0;
            @(negedge clk);
            gap_left--;
        end
        text_in.valid     = 1'b1;
        text_in.in_byte   = b;
        text_in.last_byte = fin;
        row_chk           = chk;
        row_typed         = typed;
        do @(posedge clk); while (!text_in.ready);
        burst_left--;
        @(negedge clk);
    endtask

    initial begin : stimulus
        stim_row_t  rows [$];
        logic [7:0] text_q [$];
        int         sent;
        int         n_chunks;

        rst_n             = 1'b0;
        text_in.valid     = 1'b0;
        text_in.in_byte   = 8'h00;
        text_in.last_byte = 1'b0;
        row_chk           = CHK_MODEL;
        row_typed         = '0;
        burst_left        = 0;
        gap_left          = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows
        // one-byte texts: plain, extremes, comma and hyphen at start of text
        rows.insert(rows.size(), dir_row(8'h41, 1'b1, CHK_ONE, 8'h41, 1'b1));
        rows.insert(rows.size(), dir_row(8'h00, 1'b1, CHK_ONE, 8'h00, 1'b1));
        rows.insert(rows.size(), dir_row(8'hFF, 1'b1, CHK_ONE, 8'hFF, 1'b1));
        rows.insert(rows.size(), dir_row(CH_COMMA, 1'b1, CHK_ONE, CH_COMMA, 1'b1));
        rows.insert(rows.size(), dir_row(CH_HYPHEN, 1'b1, CHK_ONE, CH_HYPHEN, 1'b1));
        // yen sign dropped as the whole text: only the empty end marker comes out
        rows.insert(rows.size(), dir_row(B_C2, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_A5, 1'b1, CHK_ONE, 8'h00, 1'b0));
        // minus sign at start, comma between digits
        rows.insert(rows.size(), dir_row(CH_HYPHEN, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(8'h35, 1'b0, CHK_MODEL, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(CH_COMMA, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(CH_0, 1'b0, CHK_MODEL, 8'h00, 1'b0));
        // degree celsius, then degree fahrenheit
        rows.insert(rows.size(), dir_row(B_E2, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_84, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_83, 1'b0, CHK_MODEL, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_E2, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_84, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_89, 1'b0, CHK_MODEL, 8'h00, 1'b0));
        // fullwidth yen dropped
        rows.insert(rows.size(), dir_row(B_EF, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_BF, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_A5, 1'b0, CHK_NONE, 8'h00, 1'b0));
        // hyphen after a letter stays a hyphen
        rows.insert(rows.size(), dir_row(8'h61, 1'b0, CHK_MODEL, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(CH_HYPHEN, 1'b0, CHK_MODEL, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(8'h37, 1'b0, CHK_MODEL, 8'h00, 1'b0));
        // degree sequence cut short by the end of text
        rows.insert(rows.size(), dir_row(B_E2, 1'b0, CHK_NONE, 8'h00, 1'b0));
        rows.insert(rows.size(), dir_row(B_84, 1'b1, CHK_MODEL, 8'h00, 1'b0));

        foreach (rows[i]) send_byte(rows[i].b, rows[i].fin, rows[i].chk, rows[i].typed);

        // random texts: mostly rule patterns with random content, some noise
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            text_q.delete();
            n_chunks = $urandom_range(1, 14);
            for (int c = 0; c < n_chunks; c++) begin
                case ($urandom_range(0, 11))
                    0, 1, 2: text_q.insert(text_q.size(), 8'(CH_0 + $urandom_range(0, 9)));
                    3: text_q.insert(text_q.size(),
                                     8'(($urandom_range(0, 1) ? CH_UA : CH_LA) +
                                        $urandom_range(0, 25)));
                    4: text_q.insert(text_q.size(), CH_COMMA);
                    5: text_q.insert(text_q.size(), CH_HYPHEN);
                    6: begin
                        text_q.insert(text_q.size(), B_E2);
                        text_q.insert(text_q.size(), B_84);
                        case ($urandom_range(0, 2))
                            0:       text_q.insert(text_q.size(), B_83);
                            1:       text_q.insert(text_q.size(), B_89);
                            default: text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                        endcase
                    end
                    7: begin
                        text_q.insert(text_q.size(), B_C2);
                        text_q.insert(text_q.size(),
                                      $urandom_range(0, 1) ? B_A5 : 8'($urandom_range(0, 255)));
                    end
                    8: begin
                        text_q.insert(text_q.size(), B_EF);
                        text_q.insert(text_q.size(), B_BF);
                        text_q.insert(text_q.size(),
                                      $urandom_range(0, 1) ? B_A5 : 8'($urandom_range(0, 255)));
                    end
                    9: begin
                        // lone prefixes, broken or cut by the end of text
                        case ($urandom_range(0, 4))
                            0: text_q.insert(text_q.size(), B_E2);
                            1: begin
                                text_q.insert(text_q.size(), B_E2);
                                text_q.insert(text_q.size(), B_84);
                            end
                            2: text_q.insert(text_q.size(), B_C2);
                            3: text_q.insert(text_q.size(), B_EF);
                            default: begin
                                text_q.insert(text_q.size(), B_EF);
                                text_q.insert(text_q.size(), B_BF);
                            end
                        endcase
                    end
                    default: text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                endcase
            end
            foreach (text_q[i])
                send_byte(text_q[i], i == text_q.size() - 1, CHK_MODEL, '0);
            sent += text_q.size();
        end
        text_in.valid = 1'b0;

        // wait for every owed result, then a little longer for strays
        while (rewritten_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
